// ===== hw/rtl/btt_pkg.sv =====
package btt_pkg;

    // operation codes
    localparam logic [1:0] OP_PROBE      = 2'd0;
    localparam logic [1:0] OP_STORE      = 2'd1;
    localparam logic [1:0] OP_NEW_SEARCH = 2'd2;
    localparam logic [1:0] OP_CLEAR      = 2'd3;

    // register map (index taken from paddr[2])
    localparam logic [0:0] REG_ALPHA_BOUND   = 1'b0;
    localparam logic [3:0] ALPHA_BOUND_RESET = 4'd1;

    localparam int          SET_SHIFT   = 2;
    localparam logic [4:0]  AGE_LIMIT   = 5'd15;
    localparam logic [4:0]  AGE_RESET   = 5'd1;
    localparam logic [8:0]  NULL_MARGIN = 9'd4;

    typedef struct packed {
        logic [1:0]         op;
        logic [63:0]        hash;
        logic [7:0]         depth;
        logic signed [15:0] value;
        logic signed [15:0] beta;
        logic [3:0]         bound;
        logic [31:0]        move;
    } btt_in_t;

    typedef struct packed {
        logic               hit;
        logic               cutoff;
        logic [3:0]         bound_out;
        logic signed [15:0] value_out;
        logic [31:0]        move_out;
        logic               null_move_ok;
    } btt_out_t;

    // one table entry, flg = {age nibble, bound code}
    typedef struct packed {
        logic [63:0] key;
        logic [15:0] val;
        logic [7:0]  dep;
        logic [7:0]  flg;
        logic [31:0] mv;
    } entry_t;

endpackage

// ===== hw/rtl/btt_mem.sv =====
module btt_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  btt_pkg::entry_t       wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output btt_pkg::entry_t       rdata
);

    btt_pkg::entry_t mem [DEPTH];
    btt_pkg::entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/btt_way_unit.sv =====
module btt_way_unit #(
    parameter int WAY_W = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              step,
    input  logic [WAY_W-1:0]  way,
    input  btt_pkg::entry_t   entry,
    input  logic [63:0]       key,
    input  logic [4:0]        age,
    output logic              found,
    output btt_pkg::entry_t   found_entry,
    output logic [WAY_W-1:0]  pick_way,
    output logic [31:0]       pick_mv
);

    logic             found_reg;
    logic             oth_v_reg;
    logic             all_v_reg;
    btt_pkg::entry_t  found_entry_reg;
    logic [WAY_W-1:0] found_way_reg;
    logic [WAY_W-1:0] oth_way_reg;
    logic [WAY_W-1:0] all_way_reg;
    logic [7:0]       oth_dep_reg;
    logic [7:0]       all_dep_reg;
    logic [31:0]      oth_mv_reg;
    logic [31:0]      all_mv_reg;

    logic is_match;
    logic oth_better;
    logic all_better;

    // one way per step: key match, other-age shallowest, overall shallowest
    always_comb
    begin
        is_match   = (entry.key == key) && !found_reg;
        oth_better = ({1'b0, entry.flg[7:4]} != age)
                     && (!oth_v_reg || (entry.dep < oth_dep_reg));
        all_better = !all_v_reg || (entry.dep < all_dep_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            oth_v_reg <= 1'b0;
            all_v_reg <= 1'b0;
        end
        else if (start)
        begin
            found_reg <= 1'b0;
            oth_v_reg <= 1'b0;
            all_v_reg <= 1'b0;
        end
        else if (step)
        begin
            if (is_match)
            begin
                found_reg <= 1'b1;
            end
            if (oth_better)
            begin
                oth_v_reg <= 1'b1;
            end
            if (all_better)
            begin
                all_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            if (is_match)
            begin
                found_entry_reg <= entry;
                found_way_reg   <= way;
            end
            if (oth_better)
            begin
                oth_way_reg <= way;
                oth_dep_reg <= entry.dep;
                oth_mv_reg  <= entry.mv;
            end
            if (all_better)
            begin
                all_way_reg <= way;
                all_dep_reg <= entry.dep;
                all_mv_reg  <= entry.mv;
            end
        end
    end

    // a key match wins, then other-age shallowest, then overall shallowest
    always_comb
    begin
        found       = found_reg;
        found_entry = found_entry_reg;
        if (found_reg)
        begin
            pick_way = found_way_reg;
            pick_mv  = found_entry_reg.mv;
        end
        else if (oth_v_reg)
        begin
            pick_way = oth_way_reg;
            pick_mv  = oth_mv_reg;
        end
        else
        begin
            pick_way = all_way_reg;
            pick_mv  = all_mv_reg;
        end
    end

endmodule

// ===== hw/rtl/bucketed_transposition_table_unit.sv =====
// 4-way set-associative transposition table with depth/age replacement
// in channel: valid/ready words of btt_in_t (op, hash, depth, value, beta, bound, move)
// out channel: valid/ready words of btt_out_t, one word per probe only
// config: apb-style port, alpha_bound_code at byte address 0, pready always high
// a probe or store reads the ways of its set one per cycle from a simple dual-port
// entry memory, feeding a shared compare unit (key match, age test, depth min)
// probe/store: busy through S_SCAN, which scans the ways over the memory read port, and
//   S_FINISH, where a store writes its entry and a probe word enters the output register
// new search: steps the age in idle, in_ready stays high
// clear table: one entry written per cycle over all NUM_SETS*WAYS entries (16384 at default)
// reset: age set to 1, alpha_bound_code set to 1, and the same clearing pass over
//   all NUM_SETS*WAYS entries runs with in_ready low; config writes are still taken
// stall: a finished probe word sits in the output register until taken; the next
//   word is accepted meanwhile, and a later probe waits in its final cycle only
//   while the previous word is still held
module bucketed_transposition_table_unit #(
    parameter int NUM_SETS = 4096,
    parameter int WAYS     = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  btt_pkg::btt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output btt_pkg::btt_out_t out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DEPTH  = NUM_SETS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;

    localparam logic [SET_W-1:0]  SET_MASK  = SET_W'(NUM_SETS - 1);
    localparam logic [ADDR_W-1:0] WAYS_A    = ADDR_W'(WAYS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [WAY_W-1:0]  LAST_WAY  = WAY_W'(WAYS - 1);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t              state_reg;
    logic [WAY_W-1:0]    way_reg;
    logic [ADDR_W-1:0]   clr_addr_reg;
    logic [4:0]          age_reg;
    logic [3:0]          alpha_reg;
    logic                out_valid_reg;
    btt_pkg::btt_out_t   out_data_reg;
    btt_pkg::btt_in_t    req_reg;

    logic                accept;
    logic                cfg_wr;
    logic [ADDR_W-1:0]   base_in;
    logic [ADDR_W-1:0]   base_req;
    logic [ADDR_W-1:0]   raddr;
    logic                we;
    logic [ADDR_W-1:0]   waddr;
    btt_pkg::entry_t     wdata;
    btt_pkg::entry_t     rdata;
    btt_pkg::entry_t     new_entry;
    btt_pkg::btt_out_t   probe_res;
    logic                out_free;
    logic                out_load;

    logic                scan_start;
    logic                scan_step;
    logic                found;
    btt_pkg::entry_t     found_entry;
    logic [WAY_W-1:0]    pick_way;
    logic [31:0]         pick_mv;

    // ---------------------------------------------------------------- config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == btt_pkg::REG_ALPHA_BOUND) ? {28'd0, alpha_reg} : 32'd0;

    // ---------------------------------------------------------------- handshakes
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    // finished probe word moves into the output register
    assign out_load  = (state_reg == S_FINISH) && (req_reg.op == btt_pkg::OP_PROBE)
                       && out_free;

    // ---------------------------------------------------------------- addressing
    // set = (hash >> 2) masked, entry address = set * WAYS + way
    assign base_in  = ADDR_W'(in_data.hash[btt_pkg::SET_SHIFT +: SET_W] & SET_MASK)
                      * WAYS_A;
    assign base_req = ADDR_W'(req_reg.hash[btt_pkg::SET_SHIFT +: SET_W] & SET_MASK)
                      * WAYS_A;

    // read way 0 on acceptance, then way k+1 while way k is evaluated
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            raddr = base_in;
        end
        else
        begin
            raddr = base_req + ADDR_W'(way_reg) + ADDR_W'(1);
        end
    end

    assign scan_start = accept;
    assign scan_step  = (state_reg == S_SCAN);

    // ---------------------------------------------------------------- store word
    always_comb
    begin
        new_entry.key = req_reg.hash;
        new_entry.val = req_reg.value;
        new_entry.dep = req_reg.depth;
        new_entry.flg = {age_reg[3:0], req_reg.bound};
        // a zero move keeps whatever the replaced way held
        new_entry.mv  = (req_reg.move != 32'd0) ? req_reg.move : pick_mv;
    end

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
            wdata = '0;
        end
        else
        begin
            we    = (state_reg == S_FINISH) && (req_reg.op == btt_pkg::OP_STORE);
            waddr = base_req + ADDR_W'(pick_way);
            wdata = new_entry;
        end
    end

    // ---------------------------------------------------------------- probe word
    always_comb
    begin
        probe_res              = '0;
        probe_res.hit          = found;
        probe_res.null_move_ok = 1'b1;
        if (found)
        begin
            probe_res.move_out = found_entry.mv;
            if (found_entry.dep >= req_reg.depth)
            begin
                probe_res.cutoff    = 1'b1;
                probe_res.bound_out = found_entry.flg[3:0];
                probe_res.value_out = found_entry.val;
            end
            // fail-low entry below beta and deep enough forbids the null move
            if ((found_entry.flg[3:0] == alpha_reg)
                && ($signed(found_entry.val) < req_reg.beta)
                && ({1'b0, req_reg.depth} <= ({1'b0, found_entry.dep}
                                              + btt_pkg::NULL_MARGIN)))
            begin
                probe_res.null_move_ok = 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            way_reg       <= '0;
            clr_addr_reg  <= '0;
            age_reg       <= btt_pkg::AGE_RESET;
            alpha_reg     <= btt_pkg::ALPHA_BOUND_RESET;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (cfg_wr && (paddr[2] == btt_pkg::REG_ALPHA_BOUND))
            begin
                alpha_reg <= pwdata[3:0];
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= probe_res;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    if (clr_addr_reg == LAST_ADDR)
                    begin
                        clr_addr_reg <= '0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (in_data.op)
                            btt_pkg::OP_NEW_SEARCH:
                            begin
                                // age runs 1..16
                                if (age_reg > btt_pkg::AGE_LIMIT)
                                begin
                                    age_reg <= btt_pkg::AGE_RESET;
                                end
                                else
                                begin
                                    age_reg <= age_reg + 5'd1;
                                end
                            end
                            btt_pkg::OP_CLEAR:
                            begin
                                state_reg <= S_CLEAR;
                            end
                            default:
                            begin
                                way_reg   <= '0;
                                state_reg <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    way_reg <= way_reg + WAY_W'(1);
                    if (way_reg == LAST_WAY)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (req_reg.op == btt_pkg::OP_PROBE)
                    begin
                        // hold here while the previous word is still unread
                        if (out_free)
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // request held for the whole operation
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_data;
        end
    end

    // ---------------------------------------------------------------- datapath
    btt_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    btt_way_unit #(
        .WAY_W (WAY_W)
    ) u_way (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .step        (scan_step),
        .way         (way_reg),
        .entry       (rdata),
        .key         (req_reg.hash),
        .age         (age_reg),
        .found       (found),
        .found_entry (found_entry),
        .pick_way    (pick_way),
        .pick_mv     (pick_mv)
    );

endmodule

// ===== hw/rtl/btt_checker.sv =====
module btt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input btt_pkg::btt_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input btt_pkg::btt_out_t out_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    // probes and clears keep the block busy after acceptance
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        && (in_data.op == btt_pkg::OP_PROBE || in_data.op == btt_pkg::OP_CLEAR)
        |=> !in_ready)
        else $error("block ready right after a probe or clear");

    // only probes produce words
    a_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op != btt_pkg::OP_PROBE |=> !$rose(out_valid))
        else $error("word produced by a non-probe operation");

    a_cut_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.cutoff |-> out_data.hit)
        else $error("cutoff without hit");

    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit
        |-> out_data.move_out == 32'd0 && out_data.null_move_ok && !out_data.cutoff)
        else $error("miss word carries entry data");

endmodule

bind bucketed_transposition_table_unit btt_checker u_btt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
